// ===== rtl/tzs_pkg.sv =====
package tzs_pkg;

    localparam int SCREEN_WIDTH_DEF  = 150;
    localparam int SCREEN_HEIGHT_DEF = 50;
    localparam int TRIG_FRAC_DEF     = 14;

    // torus geometry and shading gains
    localparam int TORUS_CENTRE = 3;
    localparam int VIEW_DIST    = 5;
    localparam int SCALE_X      = 30;
    localparam int SCALE_Y      = 15;
    localparam int LUM_GAIN     = 8;
    localparam int RAMP_LAST    = 11;

    // frame tag kept beside each depth entry
    localparam int EPOCH_BITS = 8;
    localparam int DEPTH_BITS = 16;

    typedef enum logic [1:0] {
        CFG_SIN_A = 2'd0,
        CFG_COS_A = 2'd1,
        CFG_SIN_B = 2'd2,
        CFG_COS_B = 2'd3
    } t_cfg_idx;

    function automatic logic [7:0] ramp_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h2E; // .
            4'd1:    c = 8'h2C; // ,
            4'd2:    c = 8'h2D; // -
            4'd3:    c = 8'h7E; // ~
            4'd4:    c = 8'h3A; // :
            4'd5:    c = 8'h3B; // ;
            4'd6:    c = 8'h3D; // =
            4'd7:    c = 8'h21; // !
            4'd8:    c = 8'h2A; // *
            4'd9:    c = 8'h23; // #
            4'd10:   c = 8'h24; // $
            default: c = 8'h40; // @
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/tzs_div.sv =====
module tzs_div #(
    parameter int F   = 14,
    parameter int OPW = 26
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic signed [OPW-1:0] i_den,
    output logic                  o_done,
    output logic [15:0]           o_quot
);
    // quotient of 2^(16+F) / den, one bit per cycle
    localparam int QW = 17 + F;
    localparam int CW = $clog2(QW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [OPW:0]  r_rem;
    logic [OPW:0]  r_den;
    logic [QW-1:0] r_q;

    logic [OPW:0] rem_sh;
    logic [OPW:0] n_rem;
    logic         q_bit;

    always_comb begin
        rem_sh = {r_rem[OPW-1:0], (r_cnt == CW'(QW - 1 - (16 + F)))};
        q_bit  = (rem_sh >= r_den);
        n_rem  = q_bit ? (rem_sh - r_den) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= '0;
                r_den <= {1'b0, i_den};
                r_cnt <= '0;
                r_q   <= '0;
                if (i_den[OPW-1] || i_den == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[QW-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    // saturate to the Q0.16 range
    assign o_quot = (|r_q[QW-1:16]) ? 16'hFFFF : r_q[15:0];

endmodule

// ===== rtl/tzs_depth_mem.sv =====
module tzs_depth_mem #(
    parameter int DEPTH = 7500,
    parameter int DW    = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DW-1:0]            i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DW-1:0]            o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/torus_point_zbuffer_shader_top.sv =====
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser=func, tdata=trig of theta and phi
// m_axis    out  m_axis_tvalid/m_axis_tready   tuser=written, tdata=cell, glyph, depth
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// A point item runs multiply steps on one shared multiplier, a bit-serial divide of
// 17 + F steps, the projection multiplies, then position, address, depth read and
// compare; a point off screen skips the read and compare. The block is ready for the
// next item in the same cycle that the result appears, unless a clearing pass follows.
// A frame item advances the 8-bit frame tag; a clearing pass over all W*H cells follows
// each time the tag wraps. After reset a clearing pass over all W*H cells runs first.
// The next item is taken while a result waits on m_axis; a stalled m_axis holds
// the block in its final state once a second result is ready.
module torus_point_zbuffer_shader_top
    import tzs_pkg::*;
#(
    parameter int SCREEN_WIDTH       = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT      = SCREEN_HEIGHT_DEF,
    parameter int TRIG_FRACTION_BITS = TRIG_FRAC_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // sin_theta, cos_theta, sin_phi, cos_phi
    input  logic        s_axis_tuser,  // func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // column, row, glyph, inv_depth, zero fill
    output logic        m_axis_tuser,  // written
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int F     = TRIG_FRACTION_BITS;
    localparam int OPW   = F + 12;
    localparam int PW    = 2 * OPW;
    localparam int SW    = PW + 6;
    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int XB    = $clog2(SCREEN_WIDTH);
    localparam int YB    = $clog2(SCREEN_HEIGHT);
    localparam int MW    = EPOCH_BITS + DEPTH_BITS;
    localparam int CALC_STEPS = 18;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CALC, S_DIVW, S_PROJ, S_POS, S_ADDR, S_RD, S_CMP, S_FIN
    } t_state;

    typedef enum logic [1:0] {ACC_SET, ACC_ADD, ACC_SUB, ACC_NEG} t_acc;

    typedef enum logic [3:0] {
        V_SPH, V_CPH, V_D, V_T, V_XR, V_YR, V_SPC, V_CPC, V_U, V_LUM
    } t_var;

    function automatic logic signed [OPW-1:0] trunc_q(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] a;
        logic signed [PW-1:0] s;
        a = p + (p[PW-1] ? ((PW'(1) << F) - PW'(1)) : '0);
        s = a >>> F;
        return s[OPW-1:0];
    endfunction

    function automatic logic signed [SW-1:0] trunc_pos(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] a;
        a = v + (v[SW-1] ? ((SW'(1) << (16 + F)) - SW'(1)) : '0);
        return a >>> (16 + F);
    endfunction

    t_state r_state;

    logic signed [15:0] r_sin_a, r_cos_a, r_sin_b, r_cos_b;
    logic signed [OPW-1:0] r_st, r_ct, r_sp, r_cp, r_h;
    logic signed [OPW-1:0] r_sph, r_cph, r_d, r_t, r_xr, r_yr, r_spc, r_cpc, r_u, r_lum;

    logic [4:0]           r_step;
    logic signed [PW-1:0] r_prod;
    logic                 r_wb_valid;
    t_var                 r_wb_dst;
    t_acc                 r_wb_op;
    logic [1:0]           r_pstep;
    logic signed [PW-1:0] r_px, r_py;
    logic [15:0]          r_z;
    logic                 r_inb;
    logic [XB-1:0]        r_col;
    logic [YB-1:0]        r_rowy;
    logic [3:0]           r_idx;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_clr;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic                 r_need_clr;

    logic        r_res_wr;
    logic [7:0]  r_res_col;
    logic [5:0]  r_res_row;
    logic [7:0]  r_res_glyph;
    logic [15:0] r_res_z;
    logic        r_ovalid;
    logic [39:0] r_odata;
    logic        r_ouser;

    // multiply step table
    logic signed [OPW-1:0] op_a, op_b;
    t_var                  st_dst;
    t_acc                  st_op;

    always_comb begin
        op_a   = r_sp;
        op_b   = r_h;
        st_dst = V_SPH;
        st_op  = ACC_SET;
        if (r_state == S_PROJ) begin
            op_a = (r_pstep == 2'd0) ? r_xr : r_yr;
            op_b = OPW'({1'b0, r_z});
        end else begin
            case (r_step)
                5'd0:  begin op_a = r_sp;  op_b = r_h;         st_dst = V_SPH; st_op = ACC_SET; end
                5'd1:  begin op_a = r_cp;  op_b = r_h;         st_dst = V_CPH; st_op = ACC_SET; end
                5'd2:  begin op_a = r_sph; op_b = OPW'(r_sin_a); st_dst = V_D;  st_op = ACC_ADD; end
                5'd3:  begin op_a = r_st;  op_b = OPW'(r_cos_a); st_dst = V_D;  st_op = ACC_ADD; end
                5'd4:  begin op_a = r_sph; op_b = OPW'(r_cos_a); st_dst = V_T;  st_op = ACC_SET; end
                5'd5:  begin op_a = r_st;  op_b = OPW'(r_sin_a); st_dst = V_T;  st_op = ACC_SUB; end
                5'd6:  begin op_a = r_cph; op_b = OPW'(r_cos_b); st_dst = V_XR; st_op = ACC_SET; end
                5'd7:  begin op_a = r_t;   op_b = OPW'(r_sin_b); st_dst = V_XR; st_op = ACC_SUB; end
                5'd8:  begin op_a = r_cph; op_b = OPW'(r_sin_b); st_dst = V_YR; st_op = ACC_SET; end
                5'd9:  begin op_a = r_t;   op_b = OPW'(r_cos_b); st_dst = V_YR; st_op = ACC_ADD; end
                5'd10: begin op_a = r_sp;  op_b = r_ct;        st_dst = V_SPC; st_op = ACC_SET; end
                5'd11: begin op_a = r_cp;  op_b = r_ct;        st_dst = V_CPC; st_op = ACC_SET; end
                5'd12: begin op_a = r_st;  op_b = OPW'(r_sin_a); st_dst = V_U;  st_op = ACC_SET; end
                5'd13: begin op_a = r_spc; op_b = OPW'(r_cos_a); st_dst = V_U;  st_op = ACC_SUB; end
                5'd14: begin op_a = r_spc; op_b = OPW'(r_sin_a); st_dst = V_LUM; st_op = ACC_NEG; end
                5'd15: begin op_a = r_st;  op_b = OPW'(r_cos_a); st_dst = V_LUM; st_op = ACC_SUB; end
                5'd16: begin op_a = r_cpc; op_b = OPW'(r_sin_b); st_dst = V_LUM; st_op = ACC_SUB; end
                5'd17: begin op_a = r_u;   op_b = OPW'(r_cos_b); st_dst = V_LUM; st_op = ACC_ADD; end
                default: begin
                    op_a = r_sp; op_b = r_h; st_dst = V_SPH; st_op = ACC_SET;
                end
            endcase
        end
    end

    // accumulate the truncated product into its destination
    logic signed [OPW-1:0] wb_q, wb_cur, wb_val;

    always_comb begin
        wb_q = trunc_q(r_prod);
        case (r_wb_dst)
            V_SPH:   wb_cur = r_sph;
            V_CPH:   wb_cur = r_cph;
            V_D:     wb_cur = r_d;
            V_T:     wb_cur = r_t;
            V_XR:    wb_cur = r_xr;
            V_YR:    wb_cur = r_yr;
            V_SPC:   wb_cur = r_spc;
            V_CPC:   wb_cur = r_cpc;
            V_U:     wb_cur = r_u;
            V_LUM:   wb_cur = r_lum;
            default: wb_cur = r_sph;
        endcase
        case (r_wb_op)
            ACC_SET: wb_val = wb_q;
            ACC_ADD: wb_val = wb_cur + wb_q;
            ACC_SUB: wb_val = wb_cur - wb_q;
            ACC_NEG: wb_val = -wb_q;
            default: wb_val = wb_q;
        endcase
    end

    // projection and luminance index
    logic signed [SW-1:0]    px_s, py_s, pos_x, pos_y;
    logic signed [OPW+3:0]   lum8, lum_i;
    logic                    inb;
    logic [3:0]              idx;

    always_comb begin
        px_s  = SW'(r_px) * SW'(SCALE_X);
        py_s  = SW'(r_py) * SW'(SCALE_Y);
        pos_x = trunc_pos(px_s) + SW'(SCREEN_WIDTH / 2);
        pos_y = trunc_pos(py_s) + SW'(SCREEN_HEIGHT / 2);
        inb   = (pos_x > 0) && (pos_x < SW'(SCREEN_WIDTH))
             && (pos_y > 0) && (pos_y < SW'(SCREEN_HEIGHT));
        lum8  = (OPW+4)'(r_lum) * (OPW+4)'(LUM_GAIN);
        lum_i = lum8 + (lum8[OPW+3] ? (((OPW+4)'(1) << F) - (OPW+4)'(1)) : '0);
        lum_i = lum_i >>> F;
        if (lum_i < 0) begin
            idx = 4'd0;
        end else if (lum_i > (OPW+4)'(RAMP_LAST)) begin
            idx = 4'(RAMP_LAST);
        end else begin
            idx = lum_i[3:0];
        end
    end

    // divider
    logic        div_start, div_done;
    logic [15:0] div_quot;

    assign div_start = (r_state == S_CALC) && (r_step == 5'(CALC_STEPS));

    tzs_div #(
        .F   (F),
        .OPW (OPW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // depth memory: {frame tag, depth}
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata, mem_rdata;
    logic [15:0]   stored;
    logic          pass;

    assign stored = (mem_rdata[MW-1:DEPTH_BITS] == r_epoch) ? mem_rdata[DEPTH_BITS-1:0] : '0;
    assign pass   = (r_z > stored);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = {r_epoch, r_z};
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (r_state == S_CMP) begin
            mem_we = pass;
        end
    end

    assign mem_re = (r_state == S_RD);

    tzs_depth_mem #(
        .DEPTH (CELLS),
        .DW    (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    logic s_acc;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_epoch    <= EPOCH_BITS'(1);
            r_need_clr <= 1'b0;
            r_wb_valid <= 1'b0;
            r_ovalid   <= 1'b0;
            r_step     <= '0;
            r_pstep    <= '0;
            r_sin_a    <= 16'sd0;
            r_cos_a    <= 16'sd16384;
            r_sin_b    <= 16'sd0;
            r_cos_b    <= 16'sd16384;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_SIN_A: r_sin_a <= i_cfg_data;
                    CFG_COS_A: r_cos_a <= i_cfg_data;
                    CFG_SIN_B: r_sin_b <= i_cfg_data;
                    CFG_COS_B: r_cos_b <= i_cfg_data;
                    default:   r_sin_a <= r_sin_a;
                endcase
            end

            if (m_axis_tready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end

            r_wb_valid <= (r_state == S_CALC) && (r_step != 5'(CALC_STEPS));
            if (r_wb_valid) begin
                case (r_wb_dst)
                    V_SPH:   r_sph <= wb_val;
                    V_CPH:   r_cph <= wb_val;
                    V_D:     r_d   <= wb_val;
                    V_T:     r_t   <= wb_val;
                    V_XR:    r_xr  <= wb_val;
                    V_YR:    r_yr  <= wb_val;
                    V_SPC:   r_spc <= wb_val;
                    V_CPC:   r_cpc <= wb_val;
                    V_U:     r_u   <= wb_val;
                    V_LUM:   r_lum <= wb_val;
                    default: r_sph <= wb_val;
                endcase
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_clr == AW'(CELLS - 1)) begin
                        r_clr   <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_res_wr    <= 1'b0;
                        r_res_col   <= '0;
                        r_res_row   <= '0;
                        r_res_glyph <= '0;
                        r_res_z     <= '0;
                        if (!s_axis_tuser) begin
                            // new frame: advance the tag, wipe the store when it wraps
                            if (r_epoch == '1) begin
                                r_epoch    <= EPOCH_BITS'(1);
                                r_need_clr <= 1'b1;
                            end else begin
                                r_epoch <= r_epoch + 1'b1;
                            end
                            r_state <= S_FIN;
                        end else begin
                            r_st    <= OPW'($signed(s_axis_tdata[15:0]));
                            r_ct    <= OPW'($signed(s_axis_tdata[31:16]));
                            r_sp    <= OPW'($signed(s_axis_tdata[47:32]));
                            r_cp    <= OPW'($signed(s_axis_tdata[63:48]));
                            r_h     <= OPW'($signed(s_axis_tdata[31:16]))
                                     + (OPW'(TORUS_CENTRE) << F);
                            r_d     <= OPW'(VIEW_DIST) << F;
                            r_step  <= '0;
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (r_step == 5'(CALC_STEPS)) begin
                        r_state <= S_DIVW;
                    end else begin
                        r_prod     <= op_a * op_b;
                        r_wb_dst   <= st_dst;
                        r_wb_op    <= st_op;
                        r_step     <= r_step + 1'b1;
                    end
                end
                S_DIVW: begin
                    if (div_done) begin
                        r_z     <= div_quot;
                        r_pstep <= '0;
                        r_state <= S_PROJ;
                    end
                end
                S_PROJ: begin
                    r_pstep <= r_pstep + 1'b1;
                    r_prod  <= op_a * op_b;
                    if (r_pstep == 2'd1) begin
                        r_px <= r_prod;
                    end
                    if (r_pstep == 2'd2) begin
                        r_py    <= r_prod;
                        r_state <= S_POS;
                    end
                end
                S_POS: begin
                    r_inb   <= inb;
                    r_col   <= pos_x[XB-1:0];
                    r_rowy  <= pos_y[YB-1:0];
                    r_idx   <= idx;
                    r_state <= S_ADDR;
                end
                S_ADDR: begin
                    r_addr  <= AW'(r_rowy) * AW'(SCREEN_WIDTH) + AW'(r_col);
                    r_state <= r_inb ? S_RD : S_FIN;
                end
                S_RD: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (pass) begin
                        r_res_wr    <= 1'b1;
                        r_res_col   <= 8'(r_col);
                        r_res_row   <= 6'(r_rowy);
                        r_res_glyph <= ramp_char(r_idx);
                        r_res_z     <= r_z;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // hold until the output register is free
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid   <= 1'b1;
                        r_ouser    <= r_res_wr;
                        r_odata    <= {2'b00, r_res_z, r_res_glyph, r_res_row, r_res_col};
                        r_need_clr <= 1'b0;
                        r_state    <= r_need_clr ? S_CLEAR : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

// ===== tb/torus_point_zbuffer_shader_top_test.sv =====
`timescale 1ns / 100ps

module torus_point_zbuffer_shader_top_test;
    import tzs_pkg::*;

    localparam int    W         = 150;
    localparam int    H         = 50;
    localparam longint ONE      = 64'sd1 << 14;
    localparam int    SETTLE    = 100;
    localparam int    CYCLE_CAP = 2_000_000;
    localparam string RAMP      = ".,-~:;=!*#$@";

    typedef struct packed {
        logic        shade;
        logic [15:0] sin_theta;
        logic [15:0] cos_theta;
        logic [15:0] sin_phi;
        logic [15:0] cos_phi;
    } t_point_item;

    typedef struct packed {
        logic        written;
        logic [7:0]  column;
        logic [5:0]  row;
        logic [7:0]  glyph;
        logic [15:0] inv_depth;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // sin_theta, cos_theta, sin_phi, cos_phi
    logic        s_axis_tuser = 1'b0; // func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // column, row, glyph, inv_depth, zero fill
    logic        m_axis_tuser;        // written
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;

    torus_point_zbuffer_shader_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // shading state mirrored from the block
    longint    rot_sin_a = 0, rot_cos_a = 16384, rot_sin_b = 0, rot_cos_b = 16384;
    bit [15:0] zbuf [W*H];
    bit        zbuf_live [W*H];

    t_point_item pending_points[$];
    t_pixel      expected_pixels[$];
    int          n_points = 0, n_frames = 0, n_pixels = 0, n_written = 0;
    int          n_errors = 0;
    int          cycle_count = 0;

    function automatic longint sx(input logic [15:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) / ONE;
    endfunction

    function automatic t_pixel shade_point(input t_point_item it);
        t_pixel px;
        longint st, ct, sp, cp, rad, sph, cph, spc, cpc, depth_d, t, xr, yr, lum, x, y, idx;
        longint z;
        int     cell_idx;
        px = '0;
        if (!it.shade) begin
            foreach (zbuf_live[i]) zbuf_live[i] = 1'b0;
            return px;
        end
        st = sx(it.sin_theta);
        ct = sx(it.cos_theta);
        sp = sx(it.sin_phi);
        cp = sx(it.cos_phi);
        rad  = ct + TORUS_CENTRE * ONE;
        sph  = qmul(sp, rad);
        cph  = qmul(cp, rad);
        depth_d = qmul(sph, rot_sin_a) + qmul(st, rot_cos_a) + VIEW_DIST * ONE;
        t    = qmul(sph, rot_cos_a) - qmul(st, rot_sin_a);
        xr   = qmul(cph, rot_cos_b) - qmul(t, rot_sin_b);
        yr   = qmul(cph, rot_sin_b) + qmul(t, rot_cos_b);
        if (depth_d <= 0) z = 0;
        else begin
            z = (ONE << 16) / depth_d;
            if (z > 65535) z = 65535;
        end
        x = W / 2 + (SCALE_X * xr * z) / (ONE << 16);
        y = H / 2 + (SCALE_Y * yr * z) / (ONE << 16);
        spc = qmul(sp, ct);
        cpc = qmul(cp, ct);
        lum = qmul(qmul(st, rot_sin_a) - qmul(spc, rot_cos_a), rot_cos_b)
            - qmul(spc, rot_sin_a) - qmul(st, rot_cos_a) - qmul(cpc, rot_sin_b);
        idx = (LUM_GAIN * lum) / ONE;
        if (idx < 0) idx = 0;
        if (idx > RAMP_LAST) idx = RAMP_LAST;
        if (x <= 0 || x >= W || y <= 0 || y >= H) return px;
        cell_idx = int'(y) * W + int'(x);
        if (z <= (zbuf_live[cell_idx] ? longint'(zbuf[cell_idx]) : 0)) return px;
        zbuf[cell_idx]      = z[15:0];
        zbuf_live[cell_idx] = 1'b1;
        px.written   = 1'b1;
        px.column    = x[7:0];
        px.row       = y[5:0];
        px.glyph     = RAMP[idx];
        px.inv_depth = z[15:0];
        return px;
    endfunction

    function automatic logic [15:0] q14(input real v);
        int r;
        r = $rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5));
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    task automatic push_point(input logic [15:0] st, ct, sp, cp);
        pending_points.push_back('{1'b1, st, ct, sp, cp});
    endtask

    task automatic push_angles(input real th, input real ph);
        push_point(q14($sin(th)), q14($cos(th)), q14($sin(ph)), q14($cos(ph)));
    endtask

    task automatic push_frame();
        pending_points.push_back('{1'b0, 16'h0, 16'h0, 16'h0, 16'h0});
    endtask

    function automatic logic [15:0] rand_trig();
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // Driver: bursts of items separated by random gaps
    int          burst_left = 4, gap_left = 0;
    t_point_item next_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                next_item = '{s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                              s_axis_tdata[47:32], s_axis_tdata[63:48]};
                expected_pixels.push_back(shade_point(next_item));
                if (next_item.shade) n_points++;
                else n_frames++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_points.size() > 0) begin
                    next_item = pending_points.pop_front();
                    s_axis_tuser  <= next_item.shade;
                    s_axis_tdata  <= {next_item.cos_phi, next_item.sin_phi,
                                      next_item.cos_theta, next_item.sin_theta};
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: the stall pattern on m_axis_tready is redrawn at random from time to time
    int     stall_mode = 0;
    t_pixel got, want;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            2:       m_axis_tready <= ($urandom_range(0, 1) == 0);
            default: m_axis_tready <= ((cycle_count % 13) < 9);
        endcase
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8],
                    m_axis_tdata[21:14], m_axis_tdata[37:22]};
            n_pixels++;
            if (expected_pixels.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_pixels.pop_front();
                if (want.written) n_written++;
                if (got != want || m_axis_tdata[39:38] != 2'b00) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch at result %0d: expected %p, got %p (fill %b)",
                                 n_pixels, want, got, m_axis_tdata[39:38]);
                end
            end
        end
        if (cycle_count >= CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_SIN_A: rot_sin_a = sx(val);
            CFG_COS_A: rot_cos_a = sx(val);
            CFG_SIN_B: rot_sin_b = sx(val);
            default:   rot_cos_b = sx(val);
        endcase
    endtask

    task automatic set_rotation(input logic [15:0] sa, ca, sb, cb);
        write_reg(CFG_SIN_A, sa);
        write_reg(CFG_COS_A, ca);
        write_reg(CFG_SIN_B, sb);
        write_reg(CFG_COS_B, cb);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || s_axis_tvalid || expected_pixels.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic random_points(input int count);
        int  k;
        real th, ph;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(0, 19))
                0:       push_frame();
                1, 2:    push_point(rand_trig(), rand_trig(), rand_trig(), rand_trig());
                default: begin
                    th = $urandom_range(0, 6283) / 1000.0;
                    ph = $urandom_range(0, 6283) / 1000.0;
                    push_angles(th, ph);
                end
            endcase
        end
    endtask

    initial begin
        int  ph_i, k;
        real a, b;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: quarter-turn angles, field extremes, repeat hits, frame clear
        for (k = 0; k < 16; k++) push_angles((k % 4) * 1.5708, (k / 4) * 1.5708);
        push_point(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        push_point(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        push_point(16'h0, 16'h0, 16'h0, 16'h0);
        push_point(16'h0, 16'h0, 16'h0, 16'h0);
        push_angles(0.0, 0.0);
        push_frame();
        push_angles(0.0, 0.0);
        push_point(16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384);
        drain();

        for (ph_i = 0; ph_i < 8; ph_i++) begin
            case (ph_i)
                0: set_rotation(16'sd16384, 16'h0, 16'sd16384, 16'h0);
                1: set_rotation(-16'sd16384, 16'h0, -16'sd16384, 16'h0);
                2: set_rotation(16'h0, -16'sd16384, 16'h0, -16'sd16384);
                3: set_rotation(16'h0, 16'h0, 16'h0, 16'h0);
                default: begin
                    a = $urandom_range(0, 6283) / 1000.0;
                    b = $urandom_range(0, 6283) / 1000.0;
                    set_rotation(q14($sin(a)), q14($cos(a)), q14($sin(b)), q14($cos(b)));
                end
            endcase
            // run the frame tag past its wrap once
            if (ph_i == 5) for (k = 0; k < 260; k++) push_frame();
            random_points(ph_i == 3 ? 40 : 120);
            drain();
        end

        $display("%0d points shaded (%0d landed), %0d frame starts, 9 rotation settings",
                 n_points, n_written, n_frames);
        $display("%0d results compared, %0d mismatches", n_pixels, n_errors);
        if (n_errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule
